/* design/keyboard_scancode_to_char_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the keyboard scancode decoder
// Clocked, reset-gated concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_TO_CHAR_CORE_ASSERT_SVH
`define KEYBOARD_SCANCODE_TO_CHAR_CORE_ASSERT_SVH

// Assertion on an explicit clock and active-low reset
`define KBD_SC_ASSERT_CLK(label, ck, rn, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Assertion on the module's clk and rst_n
`define KBD_SC_ASSERT(label, prop, msg) \
    `KBD_SC_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

/* design/kbd_sc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_sc_pkg
// Shared types, scancodes and character tables for the set-2 decoder.
// ----------------------------------------------------------------------------
package kbd_sc_pkg;

    localparam logic [7:0] CODE_RELEASE = 8'hF0;
    localparam logic [7:0] CODE_LSHIFT  = 8'h12;
    localparam logic [7:0] CODE_RSHIFT  = 8'h59;
    localparam logic [7:0] CODE_CAPS    = 8'h58;

    localparam logic [0:0] REG_REPORT_ON_RELEASE = 1'd0;
    localparam logic [0:0] REG_EMIT_CHARACTER    = 1'd1;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

    // Per-item decision handed from the modifier tracker to the mapper
    typedef struct packed {
        logic report;
        logic shift;
        logic caps;
    } step_info_t;

    function automatic logic [7:0] lower_char(input logic [7:0] code);
        logic [7:0] c;
        c = 8'h00;
        case (code)
            8'h0D: c = 8'h09;
            8'h0E: c = 8'h60;
            8'h15: c = 8'h71;
            8'h16: c = 8'h31;
            8'h1A: c = 8'h7A;
            8'h1B: c = 8'h73;
            8'h1C: c = 8'h61;
            8'h1D: c = 8'h77;
            8'h1E: c = 8'h32;
            8'h21: c = 8'h63;
            8'h22: c = 8'h78;
            8'h23: c = 8'h64;
            8'h24: c = 8'h65;
            8'h25: c = 8'h34;
            8'h26: c = 8'h33;
            8'h29: c = 8'h20;
            8'h2A: c = 8'h76;
            8'h2B: c = 8'h66;
            8'h2C: c = 8'h74;
            8'h2D: c = 8'h72;
            8'h2E: c = 8'h35;
            8'h31: c = 8'h6E;
            8'h32: c = 8'h62;
            8'h33: c = 8'h68;
            8'h34: c = 8'h67;
            8'h35: c = 8'h79;
            8'h36: c = 8'h36;
            8'h3A: c = 8'h6D;
            8'h3B: c = 8'h6A;
            8'h3C: c = 8'h75;
            8'h3D: c = 8'h37;
            8'h3E: c = 8'h38;
            8'h41: c = 8'h2C;
            8'h42: c = 8'h6B;
            8'h43: c = 8'h69;
            8'h44: c = 8'h6F;
            8'h45: c = 8'h30;
            8'h46: c = 8'h39;
            8'h49: c = 8'h2E;
            8'h4A: c = 8'h2F;
            8'h4B: c = 8'h6C;
            8'h4C: c = 8'h3B;
            8'h4D: c = 8'h70;
            8'h4E: c = 8'h2D;
            8'h52: c = 8'h27;
            8'h54: c = 8'h5B;
            8'h55: c = 8'h3D;
            8'h5A: c = 8'h0A;
            8'h5B: c = 8'h5D;
            8'h69: c = 8'h31;
            8'h6B: c = 8'h34;
            8'h6C: c = 8'h37;
            8'h70: c = 8'h30;
            8'h71: c = 8'h2E;
            8'h72: c = 8'h32;
            8'h73: c = 8'h35;
            8'h74: c = 8'h36;
            8'h75: c = 8'h38;
            8'h79: c = 8'h2B;
            8'h7A: c = 8'h33;
            8'h7B: c = 8'h2D;
            8'h7C: c = 8'h2A;
            8'h7D: c = 8'h39;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] upper_char(input logic [7:0] code);
        logic [7:0] c;
        c = 8'h00;
        case (code)
            8'h0D: c = 8'h09;
            8'h0E: c = 8'h7E;
            8'h15: c = 8'h51;
            8'h16: c = 8'h21;
            8'h1A: c = 8'h5A;
            8'h1B: c = 8'h53;
            8'h1C: c = 8'h41;
            8'h1D: c = 8'h57;
            8'h1E: c = 8'h40;
            8'h21: c = 8'h43;
            8'h22: c = 8'h58;
            8'h23: c = 8'h44;
            8'h24: c = 8'h45;
            8'h25: c = 8'h24;
            8'h26: c = 8'h23;
            8'h29: c = 8'h20;
            8'h2A: c = 8'h56;
            8'h2B: c = 8'h46;
            8'h2C: c = 8'h54;
            8'h2D: c = 8'h52;
            8'h2E: c = 8'h25;
            8'h31: c = 8'h4E;
            8'h32: c = 8'h42;
            8'h33: c = 8'h48;
            8'h34: c = 8'h47;
            8'h35: c = 8'h59;
            8'h36: c = 8'h5E;
            8'h3A: c = 8'h4D;
            8'h3B: c = 8'h4A;
            8'h3C: c = 8'h55;
            8'h3D: c = 8'h26;
            8'h3E: c = 8'h2A;
            8'h41: c = 8'h3C;
            8'h42: c = 8'h4B;
            8'h43: c = 8'h49;
            8'h44: c = 8'h4F;
            8'h45: c = 8'h29;
            8'h46: c = 8'h28;
            8'h49: c = 8'h3E;
            8'h4A: c = 8'h3F;
            8'h4B: c = 8'h4C;
            8'h4C: c = 8'h3A;
            8'h4D: c = 8'h50;
            8'h4E: c = 8'h5F;
            8'h52: c = 8'h7C;
            8'h54: c = 8'h7B;
            8'h55: c = 8'h2B;
            8'h5A: c = 8'h0A;
            8'h5B: c = 8'h7D;
            8'h69: c = 8'h31;
            8'h6B: c = 8'h34;
            8'h6C: c = 8'h37;
            8'h70: c = 8'h30;
            8'h71: c = 8'h2E;
            8'h72: c = 8'h32;
            8'h73: c = 8'h35;
            8'h74: c = 8'h36;
            8'h75: c = 8'h38;
            8'h79: c = 8'h2B;
            8'h7A: c = 8'h33;
            8'h7B: c = 8'h2D;
            8'h7C: c = 8'h2A;
            8'h7D: c = 8'h39;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/keyboard_scancode_to_char_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_to_char_core
// PS/2 set-2 byte stream decoder reporting key scancodes or characters.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready with code_byte, one keyboard byte per item.
// Output channel: out_valid / out_ready with key_value, never zero.
// Each input byte gives zero or one output item; prefix bytes, unreported
// press or release events and unmapped codes give none.
// Configuration: cfg_write with cfg_index selects report_on_release (0) or
// emit_character (1); cfg_data bit 0 is written. Write only while idle.
// Path: a byte is accepted into the input register, then its result moves into
// the result register and is presented there until taken.
// Throughput: one byte per cycle while out_ready is high, set by the single
// lookup between the two registers.
// Stall: while out_ready is low a full result register holds; one more byte
// is taken into the input register, then in_ready drops.
// Reset: both registers empty, shifts and caps off, caps re-armed, keys
// reported on press as characters.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_to_char_core_assert.svh"

module keyboard_scancode_to_char_core #(
    parameter int TABLE_ENTRIES = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  code_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  key_value,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [0:0]  cfg_data
);

    logic                   report_on_release_reg;
    logic                   emit_character_reg;
    logic                   s1_valid_reg;
    logic [7:0]             s1_code_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_value_reg;
    logic                   advance;
    logic                   s1_stalled;
    logic [7:0]             mapped;
    kbd_sc_pkg::step_info_t info;

    assign advance    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || advance;
    assign out_valid  = out_valid_reg;
    assign key_value  = out_value_reg;
    assign s1_stalled = s1_valid_reg && out_valid_reg && !out_ready;

    kbd_sc_state u_state (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .code              (s1_code_reg),
        .report_on_release (report_on_release_reg),
        .info              (info)
    );

    kbd_sc_map #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_map (
        .emit_character (emit_character_reg),
        .code           (s1_code_reg),
        .info           (info),
        .value          (mapped)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_on_release_reg <= 1'b0;
            emit_character_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                kbd_sc_pkg::REG_REPORT_ON_RELEASE: report_on_release_reg <= cfg_data[0];
                kbd_sc_pkg::REG_EMIT_CHARACTER:    emit_character_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= info.report && (mapped != 8'h00);
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_code_reg <= code_byte;
        end
        if (advance)
        begin
            out_value_reg <= mapped;
        end
    end

    `KBD_SC_ASSERT(a_no_zero_out, out_valid_reg |-> out_value_reg != 8'h00, "zero result")
    `KBD_SC_ASSERT(a_empty_ready, !s1_valid_reg |-> in_ready, "input refused while empty")
    `KBD_SC_ASSERT(a_s1_hold, s1_stalled |=> s1_valid_reg && $stable(s1_code_reg), "item lost")

endmodule

/* design/kbd_sc_state.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_sc_state
// Release prefix, shift and caps-lock tracking; decides whether to report.
// ----------------------------------------------------------------------------
`include "keyboard_scancode_to_char_core_assert.svh"

module kbd_sc_state
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              code,
    input  logic                    report_on_release,
    output kbd_sc_pkg::step_info_t  info
);

    logic release_pending_reg, release_pending_next;
    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic caps_on_reg, caps_on_next;
    logic caps_armed_reg, caps_armed_next;
    logic pressed;

    always_comb
    begin
        pressed         = !release_pending_reg;
        lshift_next     = lshift_reg;
        rshift_next     = rshift_reg;
        caps_on_next    = caps_on_reg;
        caps_armed_next = caps_armed_reg;

        if (code == kbd_sc_pkg::CODE_LSHIFT)
        begin
            lshift_next = pressed;
        end
        else if (code == kbd_sc_pkg::CODE_RSHIFT)
        begin
            rshift_next = pressed;
        end
        else if (code == kbd_sc_pkg::CODE_CAPS && caps_armed_reg)
        begin
            caps_on_next    = !caps_on_reg;
            caps_armed_next = 1'b0;
        end
        else if (code == kbd_sc_pkg::CODE_CAPS && !pressed)
        begin
            caps_armed_next = 1'b1;
        end

        release_pending_next = pressed && (code == kbd_sc_pkg::CODE_RELEASE);

        info.report = release_pending_reg ? report_on_release
                    : (code != kbd_sc_pkg::CODE_RELEASE) && !report_on_release;
        info.shift  = lshift_next || rshift_next;
        info.caps   = caps_on_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_pending_reg <= 1'b0;
            lshift_reg          <= 1'b0;
            rshift_reg          <= 1'b0;
            caps_on_reg         <= 1'b0;
            caps_armed_reg      <= 1'b1;
        end
        else if (step)
        begin
            release_pending_reg <= release_pending_next;
            lshift_reg          <= lshift_next;
            rshift_reg          <= rshift_next;
            caps_on_reg         <= caps_on_next;
            caps_armed_reg      <= caps_armed_next;
        end
    end

    `KBD_SC_ASSERT(a_prefix_sets, step && !release_pending_reg && code == kbd_sc_pkg::CODE_RELEASE |=> release_pending_reg, "release prefix not latched")
    `KBD_SC_ASSERT(a_prefix_clears, step && release_pending_reg |=> !release_pending_reg, "release flag not cleared")
    `KBD_SC_ASSERT(a_caps_toggle, step && code == kbd_sc_pkg::CODE_CAPS && caps_armed_reg |=> caps_on_reg != $past(caps_on_reg) && !caps_armed_reg, "caps lock did not toggle")

endmodule

/* design/kbd_sc_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kbd_sc_map
// Scancode to character lookup with shift and caps-lock case selection, or the raw scancode when characters are off.
// ----------------------------------------------------------------------------
module kbd_sc_map #(
    parameter int TABLE_ENTRIES = 128
)
(
    input  logic                    emit_character,
    input  logic [7:0]              code,
    input  kbd_sc_pkg::step_info_t  info,
    output logic [7:0]              value
);

    localparam logic [8:0] TableLimit = 9'(TABLE_ENTRIES);

    logic [7:0] lower_c;
    logic [7:0] upper_c;
    logic       letter;
    logic       use_upper;
    logic       in_range;

    always_comb
    begin
        lower_c   = kbd_sc_pkg::lower_char(code);
        upper_c   = kbd_sc_pkg::upper_char(code);
        letter    = (upper_c >= kbd_sc_pkg::CHAR_UPPER_A) && (upper_c <= kbd_sc_pkg::CHAR_UPPER_Z);
        use_upper = (letter && info.caps) != info.shift;
        in_range  = {1'b0, code} < TableLimit;

        if (!emit_character)
        begin
            value = code;
        end
        else if (!in_range)
        begin
            value = 8'h00;
        end
        else
        begin
            value = use_upper ? upper_c : lower_c;
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 set-2 scancode decoder.
// A short scripted sequence covers shift, caps lock, the release prefix and
// codes outside the tables, then random keystrokes run under every
// press/release and scancode/character mode. Each accepted byte goes through
// a local decoder model, and each output item is compared in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_ENTRIES = 128;
    localparam int KEY_COUNT     = 63;
    localparam int SQUEEZE_LEN   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_BYTES   = 85;
    localparam bit TYPED         = 1'b1;
    localparam bit PREDICTED     = 1'b0;
    localparam logic [7:0] NO_KEY = 8'h00;

    typedef struct packed {
        logic       is_reg;
        logic [0:0] reg_sel;
        logic [0:0] reg_val;
        logic [7:0] code;
        logic       fixed;
        logic [7:0] key;
    } script_row_t;

    typedef struct packed {
        logic       fixed;
        logic [7:0] key;
    } byte_note_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] code_byte;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] key_value;
    logic       cfg_write;
    logic [0:0] cfg_index;
    logic [0:0] cfg_data;

    logic [7:0] keycodes [KEY_COUNT] = '{
        8'h0D, 8'h0E,
        8'h15, 8'h16, 8'h1A, 8'h1B, 8'h1C, 8'h1D, 8'h1E,
        8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h29, 8'h2A, 8'h2B, 8'h2C,
        8'h2D, 8'h2E,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
        8'h3E,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h49, 8'h4A, 8'h4B, 8'h4C,
        8'h4D, 8'h4E,
        8'h52, 8'h54, 8'h55, 8'h5A, 8'h5B,
        8'h69, 8'h6B, 8'h6C,
        8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h79, 8'h7A, 8'h7B, 8'h7C,
        8'h7D
    };
    string lower_glyphs = "\t\140q1zsaw2cxde43 vftr5nbhgy6mju78,kio09./l;p-'[=\n]1470.2568+3-*9";
    string upper_glyphs = "\t~Q!ZSAW@CXDE$# VFTR%NBHGY^MJU&*<KIO)(>?L:P_|{+\n}1470.2568+3-*9";
    logic [7:0] lower_keys [256];
    logic [7:0] upper_keys [256];

    // decoder model state
    bit break_seen;
    bit lshift_down;
    bit rshift_down;
    bit caps_lock;
    bit caps_rearmed;
    bit on_release_mode;
    bit char_mode;

    logic [7:0] expected_keys [$];
    byte_note_t byte_notes [$];
    script_row_t script [$];

    int errors;
    int bytes_sent;
    int bytes_in;
    int results_out;
    int settings_count;
    int idle_cycles;
    bit send_calm;
    bit recv_calm;
    bit squeeze_req;
    bit squeeze_done;
    int squeeze_left;
    int stall_left;
    int results_seen;

    keyboard_scancode_to_char_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_byte (code_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .key_value (key_value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit decode_byte(input logic [7:0] code, output logic [7:0] value);
        bit pressed;
        bit report;
        bit letter;
        bit upper;
        value = NO_KEY;
        if (break_seen)
        begin
            break_seen = 1'b0;
            pressed = 1'b0;
            report = on_release_mode;
        end
        else
        begin
            pressed = 1'b1;
            report = !on_release_mode;
        end
        if (code == kbd_sc_pkg::CODE_LSHIFT)
            lshift_down = pressed;
        else if (code == kbd_sc_pkg::CODE_RSHIFT)
            rshift_down = pressed;
        else if (code == kbd_sc_pkg::CODE_CAPS && caps_rearmed)
        begin
            caps_lock = !caps_lock;
            caps_rearmed = 1'b0;
        end
        else if (code == kbd_sc_pkg::CODE_CAPS && !pressed)
            caps_rearmed = 1'b1;
        if (pressed && code == kbd_sc_pkg::CODE_RELEASE)
        begin
            break_seen = 1'b1;
            return 1'b0;
        end
        if (!report)
            return 1'b0;
        if (!char_mode)
            value = code;
        else if (code < TABLE_ENTRIES)
        begin
            letter = upper_keys[code] >= kbd_sc_pkg::CHAR_UPPER_A
                  && upper_keys[code] <= kbd_sc_pkg::CHAR_UPPER_Z;
            upper = (letter && caps_lock) != (lshift_down || rshift_down);
            value = upper ? upper_keys[code] : lower_keys[code];
        end
        return value != NO_KEY;
    endfunction

    function automatic script_row_t byte_row(input logic [7:0] code, input logic fixed,
                                             input logic [7:0] key);
        script_row_t row;
        row = '0;
        row.code = code;
        row.fixed = fixed;
        row.key = key;
        return row;
    endfunction

    function automatic script_row_t reg_row(input logic [0:0] sel, input logic [0:0] val);
        script_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_sel = sel;
        row.reg_val = val;
        return row;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] code, input logic fixed, input logic [7:0] key);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        code_byte <= code;
        byte_notes.push_back('{fixed, key});
        bytes_sent++;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] sel, input logic [0:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (sel == kbd_sc_pkg::REG_REPORT_ON_RELEASE)
            on_release_mode = val;
        else
            char_mode = val;
        @(negedge clk);
    endtask

    task automatic set_mode(input logic rel, input logic chr);
        settle();
        write_reg(kbd_sc_pkg::REG_REPORT_ON_RELEASE, rel);
        write_reg(kbd_sc_pkg::REG_EMIT_CHARACTER, chr);
        settings_count++;
    endtask

    task automatic type_keystroke();
        int pick;
        logic [7:0] key;
        pick = $urandom_range(0, 99);
        key = keycodes[$urandom_range(0, KEY_COUNT - 1)];
        if (pick < 45)
        begin
            send_byte(key, PREDICTED, NO_KEY);
            if ($urandom_range(0, 3) == 0)
                send_byte(key, PREDICTED, NO_KEY);
            if ($urandom_range(0, 2) != 0)
            begin
                send_byte(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY);
                send_byte(key, PREDICTED, NO_KEY);
            end
        end
        else if (pick < 60)
        begin
            key = $urandom_range(0, 1) ? kbd_sc_pkg::CODE_LSHIFT : kbd_sc_pkg::CODE_RSHIFT;
            if ($urandom_range(0, 1))
                send_byte(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY);
            send_byte(key, PREDICTED, NO_KEY);
        end
        else if (pick < 72)
        begin
            case ($urandom_range(0, 2))
                0: send_byte(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY);
                1:
                begin
                    send_byte(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY);
                    send_byte(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY);
                end
                default:
                begin
                    send_byte(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY);
                    send_byte(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY);
                    send_byte(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY);
                    send_byte(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY);
                end
            endcase
        end
        else if (pick < 85)
        begin
            send_byte(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY);
            send_byte(key, PREDICTED, NO_KEY);
        end
        else
            send_byte(8'($urandom_range(0, 255)), PREDICTED, NO_KEY);
    endtask

    // input and output monitor
    always @(posedge clk)
    begin
        byte_note_t note;
        logic [7:0] val;
        logic [7:0] exp_key;
        bit got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_out++;
                if (expected_keys.size() == 0)
                begin
                    $error("key_value: no item expected, got %h", key_value);
                    errors++;
                end
                else
                begin
                    exp_key = expected_keys.pop_front();
                    if (key_value !== exp_key)
                    begin
                        $error("key_value: expected %h, got %h", exp_key, key_value);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_in++;
                note = byte_notes.pop_front();
                got = decode_byte(code_byte, val);
                if (note.fixed)
                begin
                    got = note.key != NO_KEY;
                    val = note.key;
                end
                if (got)
                    expected_keys.push_back(val);
            end
        end
    end

    // output side: per-item stalls, plus one long hold-off
    always @(negedge clk)
    begin
        if (results_out != results_seen)
        begin
            results_seen = results_out;
            stall_left = recv_calm ? 0 : $urandom_range(0, 17);
        end
        if (squeeze_req && !squeeze_done)
        begin
            squeeze_left = SQUEEZE_LEN;
            squeeze_done = 1'b1;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (squeeze_left > 0)
        begin
            out_ready <= 1'b0;
            squeeze_left--;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        code_byte = 8'h00;
        cfg_write = 1'b0;
        cfg_index = kbd_sc_pkg::REG_REPORT_ON_RELEASE;
        cfg_data = 1'b0;

        for (int i = 0; i < 256; i++)
        begin
            lower_keys[i] = NO_KEY;
            upper_keys[i] = NO_KEY;
        end
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            lower_keys[keycodes[i]] = lower_glyphs[i];
            upper_keys[keycodes[i]] = upper_glyphs[i];
        end
        break_seen = 1'b0;
        lshift_down = 1'b0;
        rshift_down = 1'b0;
        caps_lock = 1'b0;
        caps_rearmed = 1'b1;
        on_release_mode = 1'b0;
        char_mode = 1'b1;
        settings_count = 1;

        // press mode, characters
        script.push_back(byte_row(8'h1C, TYPED, 8'h61));
        script.push_back(byte_row(kbd_sc_pkg::CODE_LSHIFT, TYPED, NO_KEY));
        script.push_back(byte_row(8'h1C, TYPED, 8'h41));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_LSHIFT, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_CAPS, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY));
        script.push_back(byte_row(8'h1C, PREDICTED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RSHIFT, TYPED, NO_KEY));
        script.push_back(byte_row(8'h16, PREDICTED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RSHIFT, TYPED, NO_KEY));
        // caps release re-arms, then a release while armed toggles
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_CAPS, PREDICTED, NO_KEY));
        script.push_back(byte_row(8'h7D, PREDICTED, NO_KEY));
        script.push_back(byte_row(8'hFF, TYPED, NO_KEY));
        script.push_back(byte_row(8'h00, TYPED, NO_KEY));
        // prefix followed by prefix: second one is the released key
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(reg_row(kbd_sc_pkg::REG_EMIT_CHARACTER, 1'b0));
        script.push_back(byte_row(8'h00, TYPED, NO_KEY));
        script.push_back(byte_row(8'hFF, TYPED, 8'hFF));
        script.push_back(reg_row(kbd_sc_pkg::REG_REPORT_ON_RELEASE, 1'b1));
        script.push_back(byte_row(8'h1C, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, NO_KEY));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, TYPED, kbd_sc_pkg::CODE_RELEASE));
        script.push_back(reg_row(kbd_sc_pkg::REG_EMIT_CHARACTER, 1'b1));
        script.push_back(byte_row(kbd_sc_pkg::CODE_RELEASE, PREDICTED, NO_KEY));
        script.push_back(byte_row(8'h1C, PREDICTED, NO_KEY));
        script.push_back(reg_row(kbd_sc_pkg::REG_REPORT_ON_RELEASE, 1'b0));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                settle();
                write_reg(script[i].reg_sel, script[i].reg_val);
                settings_count++;
            end
            else
                send_byte(script[i].code, script[i].fixed, script[i].key);
        end

        for (int p = 0; p < 6; p++)
        begin
            int start;
            send_calm = (p == 2 || p == 5);
            recv_calm = (p == 3 || p == 5);
            case (p)
                0: set_mode(1'b0, 1'b1);
                1: set_mode(1'b1, 1'b1);
                2: set_mode(1'b0, 1'b0);
                3: set_mode(1'b1, 1'b0);
                4: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                default: set_mode(1'b0, 1'b1);
            endcase
            if (p == 0)
                squeeze_req = 1'b1;
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                type_keystroke();
        end

        in_valid <= 1'b0;
        while (expected_keys.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Decoded %0d keyboard bytes into %0d key items across %0d mode settings",
                 bytes_in, results_out, settings_count);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
